@@ design/huffman_code_trie_assert.svh @@
// Assertion macros for the code tree block.
// Define ASSERT_OFF to compile the checks away.
`ifndef HUFFMAN_CODE_TRIE_ASSERT_SVH
`define HUFFMAN_CODE_TRIE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, held off during reset.
`define HCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hct: implication check failed");
// Next-cycle implication, held off during reset.
`define HCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hct: next-cycle check failed");
`else
`define HCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/hct_pkg.sv @@
`default_nettype none

package hct_pkg;

	// Field widths of the request and result
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CODE_W     = 32;
	localparam int unsigned CODE_IDX_W = 5;
	localparam int unsigned LEN_W      = 6;
	localparam int unsigned SYM_W      = 16;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ROOT   = 2'd2;

	// Node store access control
	typedef struct packed {
		logic rd_en;
		logic rd_fresh;
		logic wr_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

@@ design/hct_req_if.sv @@
`default_nettype none

interface hct_req_if import hct_pkg::*;;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [CODE_W-1:0]   code_bits;
	logic [LEN_W-1:0]    code_length;
	logic [SYM_W-1:0]    code_symbol;
	logic                step_bit;

	modport source (
		output valid, mode, code_bits, code_length, code_symbol, step_bit,
		input  ready
	);
	modport sink (
		input  valid, mode, code_bits, code_length, code_symbol, step_bit,
		output ready
	);
endinterface

`default_nettype wire

@@ design/hct_res_if.sv @@
`default_nettype none

interface hct_res_if import hct_pkg::*;;
	logic             valid;
	logic             ready;
	logic             moved;
	logic             at_leaf;
	logic [SYM_W-1:0] leaf_symbol;
	logic             store_full;

	modport source (
		output valid, moved, at_leaf, leaf_symbol, store_full,
		input  ready
	);
	modport sink (
		input  valid, moved, at_leaf, leaf_symbol, store_full,
		output ready
	);
endinterface

`default_nettype wire

@@ design/huffman_code_trie.sv @@
// Huffman code tree: node store in one synchronous RAM, walked by a sequencer.
// Work per request: a step reads the current node and then its child; an insert of L bits makes
// one RAM access per bit and stops early when the store runs out; return/ignored only read a node.
// Throughput: one request in flight; the next is taken once the result is registered.
// Reset: asynchronous; a one-cycle clearing pass writes the root before requests are taken.
`default_nettype none

module huffman_code_trie import hct_pkg::*; #(
	parameter int unsigned MAX_NODES    = 1024,
	parameter int unsigned MAX_CODE_LEN = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	hct_req_if.sink   req,
	hct_res_if.source res
);

`include "huffman_code_trie_assert.svh"

	localparam int unsigned NW = $clog2(MAX_NODES);
	localparam int unsigned UW = $clog2(MAX_NODES + 1);
	localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);
	localparam int unsigned DW = 2 * NW + SYM_W + 1;

	typedef struct packed {
		logic [NW-1:0]    left;
		logic [NW-1:0]    right;
		logic             mark;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_STEP,
		S_WALK,
		S_MARK,
		S_RDCUR,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [NW-1:0]     cur_q;
	logic [NW-1:0]     node_q;
	logic [UW-1:0]     nodes_used_q;
	logic [LW-1:0]     i_q;
	logic [LW-1:0]     len_q;
	logic [CODE_W-1:0] bits_q;
	logic [SYM_W-1:0]  sym_q;
	logic              sb_q;
	logic              moved_q;
	logic              full_q;
	logic              out_valid_q;
	logic              out_moved_q;
	logic              out_leaf_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_full_q;

	mem_ctl_t          mem_ctl;
	logic [NW-1:0]     rd_addr;
	logic [NW-1:0]     wr_addr;
	node_t             wr_node;
	logic [DW-1:0]     rd_data;
	node_t             rd_node;

	logic              req_fire;
	logic [LW-1:0]     len_sat;
	logic [6:0]        i_ext;
	logic              walk_bit;
	logic [NW-1:0]     walk_child;
	logic [NW-1:0]     step_child;
	logic [NW-1:0]     new_idx;
	logic [NW-1:0]     walk_next;
	logic              used_full;
	logic              last_bit;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rd_node   = node_t'(rd_data);

	// Saturate code length to the tree depth limit
	always_comb begin
		if (7'(req.code_length) > 7'(MAX_CODE_LEN)) begin
			len_sat = LW'(MAX_CODE_LEN);
		end else begin
			len_sat = LW'(req.code_length);
		end
	end

	// Walk decode: branch taken, child link, allocation target
	assign i_ext      = 7'(i_q);
	assign walk_bit   = (i_ext < 7'(CODE_W)) ? bits_q[i_ext[CODE_IDX_W-1:0]] : 1'b0;
	assign walk_child = walk_bit ? rd_node.right : rd_node.left;
	assign step_child = sb_q ? rd_node.right : rd_node.left;
	assign used_full  = (nodes_used_q == UW'(MAX_NODES));
	assign new_idx    = NW'(nodes_used_q);
	assign walk_next  = (walk_child != '0) ? walk_child : new_idx;
	assign last_bit   = ((i_q + LW'(1)) == len_q);

	// Node store access per state
	always_comb begin
		mem_ctl = '0;
		rd_addr = cur_q;
		wr_addr = node_q;
		wr_node = rd_node;
		unique case (state_q)
			S_INIT: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = '0;
				wr_node       = '0;
			end
			S_IDLE: begin
				if (req_fire) begin
					mem_ctl.rd_en = 1'b1;
					if ((req.mode == MODE_INSERT && len_sat != '0) || req.mode == MODE_ROOT) begin
						rd_addr = '0;
					end
				end
			end
			S_STEP: begin
				if (step_child != '0) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = step_child;
				end
			end
			S_WALK: begin
				if (walk_child == '0 && used_full) begin
					// out of nodes: write the node back so a fresh one holds empty links
					mem_ctl.wr_en = 1'b1;
				end else begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = walk_next;
					if (walk_child == '0) begin
						// link the new child into the parent
						mem_ctl.wr_en = 1'b1;
						if (walk_bit) begin
							wr_node.right = new_idx;
						end else begin
							wr_node.left = new_idx;
						end
					end
				end
			end
			S_MARK: begin
				mem_ctl.wr_en = 1'b1;
				wr_node.mark  = 1'b1;
				wr_node.sym   = sym_q;
			end
			S_RDCUR: begin
				mem_ctl.rd_en = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
		mem_ctl.rd_fresh = (UW'(rd_addr) >= nodes_used_q);
	end

	hct_node_store #(
		.Depth (MAX_NODES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (DW'(wr_node)),
		.rd_data (rd_data)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cur_q        <= '0;
			node_q       <= '0;
			nodes_used_q <= UW'(1);
			i_q          <= '0;
			len_q        <= '0;
			bits_q       <= '0;
			sym_q        <= '0;
			sb_q         <= 1'b0;
			moved_q      <= 1'b0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_moved_q  <= 1'b0;
			out_leaf_q   <= 1'b0;
			out_sym_q    <= '0;
			out_full_q   <= 1'b0;
		end else begin
			if (out_valid_q && res.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_fire) begin
						bits_q  <= req.code_bits;
						len_q   <= len_sat;
						sym_q   <= req.code_symbol;
						sb_q    <= req.step_bit;
						node_q  <= '0;
						i_q     <= '0;
						moved_q <= 1'b0;
						full_q  <= 1'b0;
						unique case (req.mode)
							MODE_INSERT: state_q <= (len_sat != '0) ? S_WALK : S_DONE;
							MODE_STEP:   state_q <= S_STEP;
							MODE_ROOT: begin
								cur_q   <= '0;
								state_q <= S_DONE;
							end
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_STEP: begin
					if (step_child != '0) begin
						cur_q   <= step_child;
						moved_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (walk_child == '0 && used_full) begin
						full_q  <= 1'b1;
						state_q <= S_RDCUR;
					end else begin
						if (walk_child == '0) begin
							nodes_used_q <= nodes_used_q + UW'(1);
						end
						node_q <= walk_next;
						i_q    <= i_q + LW'(1);
						if (last_bit) begin
							state_q <= S_MARK;
						end
					end
				end
				S_MARK: begin
					state_q <= S_RDCUR;
				end
				S_RDCUR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_moved_q <= moved_q;
						out_leaf_q  <= rd_node.mark;
						out_sym_q   <= rd_node.sym;
						out_full_q  <= full_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.moved       = out_moved_q;
	assign res.at_leaf     = out_leaf_q;
	assign res.leaf_symbol = out_sym_q;
	assign res.store_full  = out_full_q;

	// Checks
	`HCT_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, nodes_used_q <= UW'(MAX_NODES))
	`HCT_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_ctl.rd_en && mem_ctl.wr_en, rd_addr != wr_addr)
	`HCT_ASSERT_IMP(a_wr_allocated, clk, arst_n, mem_ctl.wr_en, UW'(wr_addr) < nodes_used_q)
	`HCT_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_fire, state_q != S_IDLE)

endmodule

`default_nettype wire

@@ design/hct_node_store.sv @@
`default_nettype none

module hct_node_store import hct_pkg::*; #(
	parameter int unsigned Depth = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mem_ctl_t                             ctl,
	input  wire logic [$clog2(Depth)-1:0]             rd_addr,
	input  wire logic [$clog2(Depth)-1:0]             wr_addr,
	input  wire logic [2*$clog2(Depth)+SYM_W:0]       wr_data,
	output logic      [2*$clog2(Depth)+SYM_W:0]       rd_data
);

	localparam int unsigned Dw = 2 * $clog2(Depth) + SYM_W + 1;

	logic [Dw-1:0] mem_q [Depth];
	logic [Dw-1:0] rd_data_q;
	logic          fresh_q;

	// Synchronous write, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Nodes at or above the fill count were never allocated: they read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b0;
		end else if (ctl.rd_en) begin
			fresh_q <= ctl.rd_fresh;
		end
	end

	assign rd_data = fresh_q ? '0 : rd_data_q;

endmodule

`default_nettype wire
